@@ rtl/frrs_pkg.sv @@
// frrs_pkg: sizes, opcodes, status codes and shared types for the
// fault-aware round-robin selector; no dependencies
`timescale 1ns / 1ps

package frrs_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = 4;                       // node_index / chosen_node field
    localparam int CNT_W     = 5;                       // node_count field and scan pointer
    localparam int PTR_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int FILL_W    = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [1:0] OP_CHOOSE  = 2'd0;
    localparam logic [1:0] OP_FAILURE = 2'd1;
    localparam logic [1:0] OP_SUCCESS = 2'd2;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_BAD_INDEX = 1'b1;

    localparam logic REG_NODE_COUNT = 1'b0;             // register index, paddr[2]

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [FILL_W-1:0] t_fill;

    typedef struct packed {
        logic  we;
        t_ptr  waddr;
        t_ptr  wdata;
        logic  re;
        t_ptr  raddr;
    } t_ram_req;

    // (a + b) mod MAX_NODES, with a below MAX_NODES and b at most MAX_NODES
    function automatic t_ptr f_wrap_add(input t_ptr a, input t_fill b);
        logic [FILL_W:0] sum;
        sum = {{(FILL_W + 1 - PTR_W){1'b0}}, a} + {1'b0, b};
        if (sum >= (FILL_W + 1)'(MAX_NODES)) begin
            sum = sum - (FILL_W + 1)'(MAX_NODES);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ rtl/frrs_fifo_ram.sv @@
// frrs_fifo_ram: storage for the ring of faulty node indexes, one write port
// and one registered read port; uses frrs_pkg
`timescale 1ns / 1ps

module frrs_fifo_ram
    import frrs_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_ptr     o_rdata
);

    t_ptr r_mem [MAX_NODES];
    t_ptr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fault_aware_round_robin_selector.sv @@
// fault_aware_round_robin_selector: top level, apb register, command port and
// sequencer; uses frrs_pkg and frrs_fifo_ram
`timescale 1ns / 1ps

// Commands are taken when start is high and busy is low, and each gives
// exactly one result beat on o_chosen_node / o_status, flagged by o_valid for
// a single cycle; the receiver cannot stall, so sample it when it appears.
// A failure report, an out-of-range report, a success report on a healthy
// node or an unused opcode shows its beat the cycle after acceptance and never
// raises busy. A choose walks the scan pointer one node per cycle through the
// fault marks, or on a wrap with faults pending reads the fault ring head as a
// recovery probe. A success report on a faulty node compacts the fault ring
// through its one read and one write port, one entry per cycle. node_count is
// at byte address 0 and is to be written by the user only while busy is low;
// the block does not enforce it; 0 behaves as 1 and values above 16 behave as 16.

module fault_aware_round_robin_selector
    import frrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_opcode,
    input  logic [IDX_W-1:0]  i_node_index,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_chosen_node,
    output logic              o_status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_WALK  = 2'd3;

    logic [1:0]           r_state,  n_state;
    logic [CNT_W-1:0]     r_nodes;
    logic [CNT_W-1:0]     r_sp,     n_sp;
    logic [MAX_NODES-1:0] r_marks,  n_marks;
    t_ptr                 r_head,   n_head;
    t_fill                r_fill,   n_fill;
    t_fill                r_step,   n_step;
    t_fill                r_rd_i,   n_rd_i;
    t_fill                r_cnt,    n_cnt;
    logic                 r_pend,   n_pend;
    t_ptr                 r_idx,    n_idx;
    logic                 r_valid,  n_valid;
    logic [IDX_W-1:0]     r_chosen, n_chosen;
    logic                 r_status, n_status;

    logic [CNT_W-1:0] w_n;
    logic             w_accept;
    logic             w_wr;
    logic             w_wrap;
    logic [CNT_W-1:0] w_cur;
    t_ram_req         w_req;
    t_ptr             w_rdata;

    frrs_fifo_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // effective node count
    always_comb begin
        if (r_nodes == '0) begin
            w_n = CNT_W'(1);
        end else if (r_nodes > CNT_W'(MAX_NODES)) begin
            w_n = CNT_W'(MAX_NODES);
        end else begin
            w_n = r_nodes;
        end
    end

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT)
                  ? {{(DATA_W - CNT_W){1'b0}}, r_nodes} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= CNT_W'(1);
        end else if (w_wr && paddr[2] == REG_NODE_COUNT) begin
            r_nodes <= pwdata[CNT_W-1:0];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_wrap   = (r_sp >= w_n);
    assign w_cur    = w_wrap ? '0 : r_sp;

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_marks  = r_marks;
        n_head   = r_head;
        n_fill   = r_fill;
        n_step   = r_step;
        n_rd_i   = r_rd_i;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_chosen = r_chosen;
        n_status = r_status;
        w_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_chosen = '0;
                    n_status = ST_OK;
                    if (i_opcode == OP_CHOOSE) begin
                        n_step  = '0;
                        n_state = S_SCAN;
                    end else if (i_opcode == OP_FAILURE || i_opcode == OP_SUCCESS) begin
                        if ({1'b0, i_node_index} >= w_n) begin
                            n_status = ST_BAD_INDEX;
                            n_valid  = 1'b1;
                        end else if (i_opcode == OP_FAILURE) begin
                            n_valid = 1'b1;
                            if (!r_marks[PTR_W'(i_node_index)]) begin
                                n_marks[PTR_W'(i_node_index)] = 1'b1;
                                if (r_fill < t_fill'(MAX_NODES)) begin
                                    w_req.we    = 1'b1;
                                    w_req.waddr = f_wrap_add(r_head, r_fill);
                                    w_req.wdata = PTR_W'(i_node_index);
                                    n_fill      = r_fill + 1'b1;
                                end
                            end
                        end else if (r_marks[PTR_W'(i_node_index)]) begin
                            n_marks[PTR_W'(i_node_index)] = 1'b0;
                            n_idx   = PTR_W'(i_node_index);
                            n_rd_i  = '0;
                            n_cnt   = '0;
                            n_pend  = 1'b0;
                            n_state = S_WALK;
                        end else begin
                            n_valid = 1'b1;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end

            S_SCAN: begin
                if (w_wrap && r_fill != '0) begin
                    // pointer wrapped with faults pending: rotate the ring head
                    n_sp        = '0;
                    w_req.re    = 1'b1;
                    w_req.raddr = r_head;
                    n_state     = S_PROBE;
                end else begin
                    n_sp = w_cur + 1'b1;
                    if (!r_marks[w_cur[PTR_W-1:0]]) begin
                        n_chosen = IDX_W'(w_cur);
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_step == FILL_W'(w_n)) begin
                        n_chosen = '0;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end

            S_PROBE: begin
                w_req.we    = 1'b1;
                w_req.waddr = f_wrap_add(r_head, r_fill);
                w_req.wdata = w_rdata;
                n_head      = f_wrap_add(r_head, t_fill'(1));
                n_chosen    = IDX_W'(w_rdata);
                n_valid     = 1'b1;
                n_state     = S_IDLE;
            end

            S_WALK: begin
                // reads run one entry ahead of the compare; writes land at or
                // below the compared slot, so nothing unread is overwritten
                if (r_pend && w_rdata != r_idx) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = f_wrap_add(r_head, r_cnt);
                    w_req.wdata = w_rdata;
                    n_cnt       = r_cnt + 1'b1;
                end
                if (r_rd_i < r_fill) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = f_wrap_add(r_head, r_rd_i);
                    n_rd_i      = r_rd_i + 1'b1;
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_fill  = r_cnt;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_marks <= '0;
            r_head  <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_marks <= n_marks;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_rd_i   <= n_rd_i;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_chosen <= n_chosen;
        r_status <= n_status;
    end

    assign o_valid       = r_valid;
    assign o_chosen_node = r_chosen;
    assign o_status      = r_status;

endmodule

@@ rtl/frrs_checker.sv @@
// frrs_checker: port-level checks on the selector's command and result beats,
// bound to the top level; uses frrs_pkg
`timescale 1ns / 1ps

module frrs_checker
    import frrs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       i_opcode,
    input logic             o_valid,
    input logic [IDX_W-1:0] o_chosen_node,
    input logic             o_status
);

    // an error beat never names a node
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BAD_INDEX |-> o_chosen_node == '0)
        else $error("error beat carries a node index");

    // a failure report answers in the next cycle
    a_fail_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OP_FAILURE |=> o_valid && !busy)
        else $error("failure report did not answer next cycle");

    // no beat without a command while idle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_valid)
        else $error("result beat without a command");

    // a choose always occupies the sequencer
    a_choose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OP_CHOOSE |=> busy && !o_valid)
        else $error("choose did not raise busy");

endmodule

bind fault_aware_round_robin_selector frrs_checker u_frrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_opcode      (i_opcode),
    .o_valid       (o_valid),
    .o_chosen_node (o_chosen_node),
    .o_status      (o_status)
);

@@ test/tb_fault_aware_round_robin_selector.sv @@
// tb_fault_aware_round_robin_selector: self-checking bench for the fault-aware
// round-robin selector; directed and random commands checked against a predictor
// depends on frrs_pkg and fault_aware_round_robin_selector
`timescale 1ns / 1ps

module tb_fault_aware_round_robin_selector;
    import frrs_pkg::*;

    localparam logic [1:0]        OP_UNUSED       = 2'd3;
    localparam logic [ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
    localparam int                CYCLE_LIMIT     = 500000;
    localparam int                PHASE_ITEMS     = 212;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
    } t_sel_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             status;
    } t_sel_beat;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              start        = 1'b0;
    logic              busy;
    logic [1:0]        i_opcode     = OP_CHOOSE;
    logic [IDX_W-1:0]  i_node_index = '0;
    logic              o_valid;
    logic [IDX_W-1:0]  o_chosen_node;
    logic              o_status;

    t_sel_cmd  pending_cmds[$];
    t_sel_beat expected_beats[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        idle_left   = 0;
    bit        quiet_phase = 1'b0;

    // predictor state
    int        model_count = 1;
    int        scan_ptr    = 0;
    bit        fault_mark [MAX_NODES];
    bit [3:0]  fault_ring [MAX_NODES];
    int        ring_head   = 0;
    int        ring_fill   = 0;

    fault_aware_round_robin_selector dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int eff_count(input int c);
        if (c == 0) return 1;
        if (c > MAX_NODES) return MAX_NODES;
        return c;
    endfunction

    // applies one command to the predictor state and returns the beat it gives
    function automatic t_sel_beat predict_outcome(input logic [1:0] op,
                                                  input logic [IDX_W-1:0] idx);
        t_sel_beat r;
        int        n;
        int        step;
        int        slot;
        int        kept;
        bit        done;
        int        keep [MAX_NODES];
        r.node   = '0;
        r.status = ST_OK;
        n        = eff_count(model_count);
        done     = 1'b0;
        case (op)
            OP_CHOOSE: begin
                for (step = 0; step <= n && !done; step++) begin
                    if (scan_ptr >= n) begin
                        scan_ptr = 0;
                        // wrap with faults pending: rotate the ring head as a probe
                        if (ring_fill != 0) begin
                            r.node = fault_ring[ring_head];
                            fault_ring[(ring_head + ring_fill) % MAX_NODES] =
                                fault_ring[ring_head];
                            ring_head = (ring_head + 1) % MAX_NODES;
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        slot = scan_ptr;
                        scan_ptr++;
                        if (!fault_mark[slot]) begin
                            r.node = slot[IDX_W-1:0];
                            done = 1'b1;
                        end
                    end
                end
            end
            OP_FAILURE, OP_SUCCESS: begin
                if (int'(idx) >= n) begin
                    r.status = ST_BAD_INDEX;
                end else if (op == OP_FAILURE) begin
                    if (!fault_mark[idx]) begin
                        fault_mark[idx] = 1'b1;
                        if (ring_fill < MAX_NODES) begin
                            fault_ring[(ring_head + ring_fill) % MAX_NODES] = idx;
                            ring_fill++;
                        end
                    end
                end else if (fault_mark[idx]) begin
                    fault_mark[idx] = 1'b0;
                    kept = 0;
                    for (slot = 0; slot < ring_fill; slot++) begin
                        if (fault_ring[(ring_head + slot) % MAX_NODES] != idx) begin
                            keep[kept] = fault_ring[(ring_head + slot) % MAX_NODES];
                            kept++;
                        end
                    end
                    for (slot = 0; slot < kept; slot++) begin
                        fault_ring[(ring_head + slot) % MAX_NODES] = keep[slot][3:0];
                    end
                    ring_fill = kept;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // command driver
    always @(posedge i_clk) begin : drive
        t_sel_cmd nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_beats.push_back(predict_outcome(i_opcode, i_node_index));
                idle_left = pick_gap();
            end
            if (start && busy) begin
                // hold the command until it is taken
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                start        <= 1'b1;
                i_opcode     <= nxt.op;
                i_node_index <= nxt.idx;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_sel_beat exp_beat;
        if (i_rst_n && o_valid) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat chosen_node %0d status %0d",
                         $time, o_chosen_node, o_status);
                error_count++;
            end else begin
                exp_beat = expected_beats.pop_front();
                if (o_chosen_node !== exp_beat.node) begin
                    $display("%0t: chosen_node expected %0d actual %0d",
                             $time, exp_beat.node, o_chosen_node);
                    error_count++;
                end
                if (o_status !== exp_beat.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_beat.status, o_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        t_sel_cmd c;
        c.op  = op;
        c.idx = idx;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || expected_beats.size() != 0 || start || busy) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    // apb write of node_count followed by a read back
    task automatic set_node_count(input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        model_count = int'(value[CNT_W-1:0]);
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== value[CNT_W-1:0]) begin
            $display("%0t: node_count read expected %0d actual %0d",
                     $time, value[CNT_W-1:0], prdata[CNT_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_random_cmds(input int count, input int fail_pct, input int succ_pct);
        int r;
        int n;
        logic [1:0] op;
        logic [IDX_W-1:0] idx;
        n = eff_count(model_count);
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < fail_pct) op = OP_FAILURE;
            else if (r < fail_pct + succ_pct) op = OP_SUCCESS;
            else if (r < fail_pct + succ_pct + 5) op = OP_UNUSED;
            else op = OP_CHOOSE;
            // mostly nodes in range, some anywhere in the field
            if ($urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, n - 1));
            else idx = IDX_W'($urandom_range(0, 15));
            push_cmd(op, idx);
        end
    endtask

    initial begin
        int phase_counts [8];
        int p;
        phase_counts = '{16, 5, 0, 31, 16, 2, 17, 9};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single node after reset
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_CHOOSE, 4'd15);
        push_cmd(OP_FAILURE, 4'd0);
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_FAILURE, 4'd1);
        push_cmd(OP_FAILURE, 4'd15);
        push_cmd(OP_UNUSED, 4'd15);
        push_cmd(OP_SUCCESS, 4'd0);
        push_cmd(OP_CHOOSE, 4'd0);
        wait_idle();

        set_node_count(32'd16);
        push_cmd(OP_FAILURE, 4'd15);
        push_cmd(OP_FAILURE, 4'd0);
        push_cmd(OP_FAILURE, 4'd15);
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_SUCCESS, 4'd15);
        push_cmd(OP_SUCCESS, 4'd5);
        push_cmd(OP_SUCCESS, 4'd0);
        push_cmd(OP_UNUSED, 4'd0);
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_FAILURE, 4'd10);
        push_cmd(OP_FAILURE, 4'd5);
        push_cmd(OP_CHOOSE, 4'd0);
        push_cmd(OP_CHOOSE, 4'd0);
        wait_idle();

        // random phases; faults left from a large count go stale at a small one
        phase_counts[7] = $urandom_range(0, 31);
        for (p = 0; p < 8; p++) begin
            set_node_count({$urandom_range(0, 1) ? 27'($urandom()) : 27'd0,
                            5'(phase_counts[p])});
            quiet_phase = (p % 3 == 1);
            if (p == 0 || p == 4) add_random_cmds(PHASE_ITEMS, 55, 5);
            else add_random_cmds(PHASE_ITEMS, $urandom_range(10, 50), $urandom_range(5, 30));
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
